### hw/rtl/bounded_deque_with_indexed_insert_defines.svh
// Assertion macros used by the deque top-level RTL.
`ifndef BOUNDED_DEQUE_WITH_INDEXED_INSERT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_INDEXED_INSERT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/bdq_pkg.sv
package bdq_pkg;

  // Storage geometry
  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);

  // Item field widths
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = COUNT_W;

  // Request codes
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_shift;
    logic shift_last;
    logic out_free;
  } dp_status_t;

  // Ring slot of logical offset off from head; both inputs below CAPACITY.
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (IDX_W+1)'(CAPACITY)) begin
      s = s - (IDX_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

### hw/rtl/bdq_ctrl.sv
module bdq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  bdq_pkg::dp_status_t   st,
  output bdq_pkg::cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SHRD  = 6'b000100,
    S_SHWR  = 6'b001000,
    S_INSWR = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = st.start_shift ? S_SHRD : S_DONE;
      end
      S_SHRD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SHWR;
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_next   = st.shift_last ? S_INSWR : S_SHRD;
      end
      S_INSWR: begin
        cmd.ins_wr = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/bdq_dp.sv
module bdq_dp (
  input  logic                clk,
  input  logic                rst,
  input  bdq_pkg::req_t       req,
  input  bdq_pkg::cmd_t       cmd,
  output bdq_pkg::dp_status_t st,
  input  logic                rsp_stall,
  output logic                rsp_valid,
  output bdq_pkg::rsp_t       rsp
);

  bdq_pkg::req_t                       req_q;
  logic [bdq_pkg::IDX_W-1:0]           head, head_next;
  logic [bdq_pkg::CNT_W-1:0]           count, count_next;
  logic [bdq_pkg::STATUS_W-1:0]        status_q, status_next;
  logic                                pop_q, pop_next;
  logic [bdq_pkg::IDX_W-1:0]           shift_idx, shift_next;
  logic [bdq_pkg::DATA_W-1:0]          mem [bdq_pkg::CAPACITY];
  logic [bdq_pkg::DATA_W-1:0]          rdata;

  logic                                we, re, full, empty;
  logic [bdq_pkg::IDX_W-1:0]           waddr, raddr, head_inc, head_dec, sh_m1;
  logic [bdq_pkg::DATA_W-1:0]          wdata;
  logic [bdq_pkg::CNT_W-1:0]           cnt_m1;

  assign full     = (count == bdq_pkg::CNT_W'(bdq_pkg::CAPACITY));
  assign empty    = (count == '0);
  assign cnt_m1   = count - 1'b1;
  assign sh_m1    = shift_idx - 1'b1;
  assign head_inc = (head == bdq_pkg::IDX_W'(bdq_pkg::CAPACITY - 1)) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? bdq_pkg::IDX_W'(bdq_pkg::CAPACITY - 1) : head - 1'b1;

  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = status_q;
    pop_next    = pop_q;
    shift_next  = shift_idx;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = head;
    raddr       = head;
    wdata       = req_q.value[bdq_pkg::DATA_W-1:0];
    st.start_shift = 1'b0;
    st.shift_last  = (sh_m1 == bdq_pkg::IDX_W'(req_q.position));
    st.out_free    = !rsp_valid || !rsp_stall;

    if (cmd.exec) begin
      status_next = bdq_pkg::ST_OK;
      pop_next    = 1'b0;
      case (req_q.func)
        bdq_pkg::FN_PUSH_BACK: begin
          if (full) begin
            status_next = bdq_pkg::ST_FULL;
          end else begin
            we         = 1'b1;
            waddr      = bdq_pkg::slot(head, count[bdq_pkg::IDX_W-1:0]);
            count_next = count + 1'b1;
          end
        end
        bdq_pkg::FN_PUSH_FRONT: begin
          if (full) begin
            status_next = bdq_pkg::ST_FULL;
          end else begin
            we         = 1'b1;
            waddr      = head_dec;
            head_next  = head_dec;
            count_next = count + 1'b1;
          end
        end
        bdq_pkg::FN_POP_FRONT: begin
          if (empty) begin
            status_next = bdq_pkg::ST_EMPTY;
          end else begin
            re         = 1'b1;
            raddr      = head;
            pop_next   = 1'b1;
            head_next  = head_inc;
            count_next = cnt_m1;
          end
        end
        bdq_pkg::FN_POP_BACK: begin
          if (empty) begin
            status_next = bdq_pkg::ST_EMPTY;
          end else begin
            re         = 1'b1;
            raddr      = bdq_pkg::slot(head, cnt_m1[bdq_pkg::IDX_W-1:0]);
            pop_next   = 1'b1;
            count_next = cnt_m1;
          end
        end
        bdq_pkg::FN_INSERT: begin
          if (empty) begin
            we         = 1'b1;
            waddr      = head;
            count_next = bdq_pkg::CNT_W'(1);
          end else if (full) begin
            status_next = bdq_pkg::ST_FULL;
          end else if (req_q.position == '0 ||
                       bdq_pkg::CNT_W'(req_q.position) >= count) begin
            status_next = bdq_pkg::ST_BADPOS;
          end else begin
            st.start_shift = 1'b1;
            shift_next     = count[bdq_pkg::IDX_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end

    // Move entry i-1 up to i, one entry per read/write pair
    if (cmd.shift_rd) begin
      re    = 1'b1;
      raddr = bdq_pkg::slot(head, sh_m1);
    end
    if (cmd.shift_wr) begin
      we         = 1'b1;
      waddr      = bdq_pkg::slot(head, shift_idx);
      wdata      = rdata;
      shift_next = sh_m1;
    end
    if (cmd.ins_wr) begin
      we         = 1'b1;
      waddr      = bdq_pkg::slot(head, bdq_pkg::IDX_W'(req_q.position));
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    shift_idx <= shift_next;
    if (cmd.load_out) begin
      rsp.popped_value <= pop_q ? bdq_pkg::VALUE_W'(rdata) : '0;
      rsp.status       <= status_q;
      rsp.count        <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      status_q  <= bdq_pkg::ST_OK;
      pop_q     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      head     <= head_next;
      count    <= count_next;
      status_q <= status_next;
      pop_q    <= pop_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/bounded_deque_with_indexed_insert.sv
// Channel   Dir   Handshake            Payload
// req       in    req_valid/req_stall  bdq_pkg::req_t (func, position, value)
// rsp       out   rsp_valid/rsp_stall  bdq_pkg::rsp_t (popped_value, status, count)
//
// One item in flight. A push, pop, error or no-op runs through the execute
// state to the done state, loads its result there and returns to idle.
// An insert at position n on a list of count entries adds count-n read/write
// pairs for the single-port ring memory to move entries up, then one write.
// The result register lets a new item be taken while the last result waits.
// Reset (rst, synchronous) empties the deque; the ring memory is not cleared.
// A stalled result holds the block in its final state until the slot frees.
`include "bounded_deque_with_indexed_insert_defines.svh"

module bounded_deque_with_indexed_insert (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bdq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bdq_pkg::rsp_t rsp
);

  bdq_pkg::cmd_t       cmd;
  bdq_pkg::dp_status_t st;

  // Result decode for the checks below
  logic rsp_is_empty, rsp_is_full, rsp_none, rsp_at_cap, rsp_over;

  // Sequencer: accept, execute, optional shift loop, result load
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Ring store, head/count, request and result registers
  bdq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  assign rsp_is_empty = (rsp.status == bdq_pkg::ST_EMPTY);
  assign rsp_is_full  = (rsp.status == bdq_pkg::ST_FULL);
  assign rsp_none     = (rsp.count == '0) && (rsp.popped_value == '0);
  assign rsp_at_cap   = (rsp.count == bdq_pkg::COUNT_W'(bdq_pkg::CAPACITY));
  assign rsp_over     = (rsp.count > bdq_pkg::COUNT_W'(bdq_pkg::CAPACITY));

  // Block is busy the cycle after it takes an item.
  `BDQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "no busy after accept")
  // An empty status only happens on an empty list and never carries data.
  `BDQ_ASSERT_NOW(a_empty_status, rsp_valid && rsp_is_empty, rsp_none, "empty status with data")
  // A full status only happens at capacity.
  `BDQ_ASSERT_NOW(a_full_status, rsp_valid && rsp_is_full, rsp_at_cap, "full status below capacity")
  // Count never exceeds capacity.
  `BDQ_ASSERT_NOW(a_count_bound, rsp_valid, !rsp_over, "count above capacity")

endmodule

### verif/bounded_deque_with_indexed_insert_test.sv
module bounded_deque_with_indexed_insert_test;

  // func codes the block treats as no-ops
  localparam logic [bdq_pkg::FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [bdq_pkg::FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1120;
  localparam int QUIET_TAIL   = 150;  // last items run with no gaps or stalls
  localparam int DRAIN_CYCLES = 60;   // longest insert shift plus slack

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  bdq_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  bdq_pkg::rsp_t rsp;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bounded_deque_with_indexed_insert u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // ---------------------------------------------------------------------------
  // Deque mirror: ring of CAPACITY entries, logical index i at (head + i) mod
  // CAPACITY. Only entries inside dq_count are ever read.
  // ---------------------------------------------------------------------------
  logic [bdq_pkg::DATA_W-1:0] dq_ring [bdq_pkg::CAPACITY];
  int                         dq_head  = 0;
  int                         dq_count = 0;

  bdq_pkg::rsp_t pending_q[$];   // results owed by the block, oldest first
  int            mismatches = 0;
  bit            gaps_on    = 1'b1;

  function automatic int ring_at(input int off);
    return (dq_head + off) % bdq_pkg::CAPACITY;
  endfunction

  // Applies one request to the mirror and returns the result it should give.
  function automatic bdq_pkg::rsp_t apply_request(input bdq_pkg::req_t r);
    bdq_pkg::rsp_t res;
    int            i;
    res        = '0;
    res.status = bdq_pkg::ST_OK;
    case (r.func)
      bdq_pkg::FN_PUSH_BACK, bdq_pkg::FN_PUSH_FRONT: begin
        if (dq_count == bdq_pkg::CAPACITY) begin
          res.status = bdq_pkg::ST_FULL;
        end else if (r.func == bdq_pkg::FN_PUSH_BACK) begin
          dq_ring[ring_at(dq_count)] = r.value;
          dq_count++;
        end else begin
          dq_head = ring_at(bdq_pkg::CAPACITY - 1);
          dq_ring[dq_head] = r.value;
          dq_count++;
        end
      end
      bdq_pkg::FN_POP_FRONT, bdq_pkg::FN_POP_BACK: begin
        if (dq_count == 0) begin
          res.status = bdq_pkg::ST_EMPTY;
        end else if (r.func == bdq_pkg::FN_POP_FRONT) begin
          res.popped_value = dq_ring[dq_head];
          dq_head = ring_at(1);
          dq_count--;
        end else begin
          res.popped_value = dq_ring[ring_at(dq_count - 1)];
          dq_count--;
        end
      end
      bdq_pkg::FN_INSERT: begin
        // empty list takes any position; full beats bad position
        if (dq_count == 0) begin
          dq_ring[dq_head] = r.value;
          dq_count = 1;
        end else if (dq_count == bdq_pkg::CAPACITY) begin
          res.status = bdq_pkg::ST_FULL;
        end else if (r.position == 0 || r.position >= dq_count) begin
          res.status = bdq_pkg::ST_BADPOS;
        end else begin
          for (i = dq_count; i > r.position; i--) begin
            dq_ring[ring_at(i)] = dq_ring[ring_at(i - 1)];
          end
          dq_ring[ring_at(r.position)] = r.value;
          dq_count++;
        end
      end
      default: ;  // spare codes change nothing
    endcase
    res.count = bdq_pkg::COUNT_W'(dq_count);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with typed set carry a hand-written result; the rest
  // take theirs from the mirror.
  // ---------------------------------------------------------------------------
  typedef struct {
    bdq_pkg::req_t rq;
    bit            typed;
    bdq_pkg::rsp_t want;
  } step_t;

  step_t plan[$];

  function automatic void plan_row(input logic [bdq_pkg::FUNC_W-1:0] f,
                                   input logic [bdq_pkg::POS_W-1:0] p,
                                   input logic [bdq_pkg::VALUE_W-1:0] v,
                                   input bit typed,
                                   input logic [bdq_pkg::VALUE_W-1:0] pv,
                                   input logic [bdq_pkg::STATUS_W-1:0] st,
                                   input int n);
    step_t s;
    s.rq.func              = f;
    s.rq.position          = p;
    s.rq.value             = v;
    s.typed                = typed;
    s.want.popped_value    = pv;
    s.want.status          = st;
    s.want.count           = bdq_pkg::COUNT_W'(n);
    plan.push_back(s);
  endfunction

  function automatic logic [bdq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [bdq_pkg::FUNC_W-1:0] FN_POS_SPARE();
    return bdq_pkg::FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
  endfunction

  // Random request biased by direction: filling pushes/inserts, draining pops,
  // so the count swings between empty and full many times.
  function automatic bdq_pkg::req_t random_request(input bit filling);
    bdq_pkg::req_t r;
    int            pick;
    pick       = $urandom_range(0, 99);
    r.value    = pick_value();
    r.position = bdq_pkg::POS_W'($urandom());
    if (pick < 5) begin
      r.func = FN_POS_SPARE();
    end else if (pick < (filling ? 35 : 13)) begin
      r.func = bdq_pkg::FN_PUSH_BACK;
    end else if (pick < (filling ? 60 : 20)) begin
      r.func = bdq_pkg::FN_PUSH_FRONT;
    end else if (pick < (filling ? 85 : 25)) begin
      r.func = bdq_pkg::FN_INSERT;
      // mostly a legal interior slot, sometimes anything
      if (dq_count > 1 && $urandom_range(0, 4) != 0) begin
        r.position = bdq_pkg::POS_W'($urandom_range(1, dq_count - 1));
      end
    end else if (pick < (filling ? 93 : 63)) begin
      r.func = bdq_pkg::FN_POP_FRONT;
    end else begin
      r.func = bdq_pkg::FN_POP_BACK;
    end
    return r;
  endfunction

  // Offer one item, hold it through stalls, then book its result on accept.
  task automatic send_item(input bdq_pkg::req_t r, input bit typed,
                           input bdq_pkg::rsp_t want);
    bdq_pkg::rsp_t predicted;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = apply_request(r);
    pending_q.push_back(typed ? want : predicted);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    int k;
    bit filling;

    // after reset: pop on empty, spare code, insert into empty at top position, insert at position 0 refused
    plan_row(bdq_pkg::FN_POP_FRONT, 4'd0, 32'h1234_5678, 1'b1, '0, bdq_pkg::ST_EMPTY, 0);
    plan_row(FN_SPARE_LO, 4'd9, 32'hFFFF_FFFF, 1'b1, '0, bdq_pkg::ST_OK, 0);
    plan_row(bdq_pkg::FN_INSERT, 4'd15, 32'h7FFF_FFFF, 1'b1, '0, bdq_pkg::ST_OK, 1);
    plan_row(bdq_pkg::FN_INSERT, 4'd0, 32'h0000_0001, 1'b1, '0, bdq_pkg::ST_BADPOS, 1);
    // popping the only item empties the list
    plan_row(bdq_pkg::FN_POP_BACK, 4'd0, '0, 1'b1, 32'h7FFF_FFFF, bdq_pkg::ST_OK, 0);
    // fill to capacity from both ends
    for (i = 0; i < bdq_pkg::CAPACITY; i++) begin
      plan_row(i[0] ? bdq_pkg::FN_PUSH_FRONT : bdq_pkg::FN_PUSH_BACK,
               bdq_pkg::POS_W'(i), pick_value(), 1'b0, '0, bdq_pkg::ST_OK, 0);
    end
    // full: both pushes and insert refused
    plan_row(bdq_pkg::FN_PUSH_BACK, 4'd0, 32'h8000_0000, 1'b1, '0, bdq_pkg::ST_FULL, 16);
    plan_row(bdq_pkg::FN_PUSH_FRONT, 4'd0, 32'h7FFF_FFFF, 1'b1, '0, bdq_pkg::ST_FULL, 16);
    plan_row(bdq_pkg::FN_INSERT, 4'd5, 32'h0000_0000, 1'b1, '0, bdq_pkg::ST_FULL, 16);
    plan_row(bdq_pkg::FN_POP_FRONT, 4'd0, '0, 1'b0, '0, bdq_pkg::ST_OK, 0);
    // position equal to count is out of range
    plan_row(bdq_pkg::FN_INSERT, 4'd15, 32'hDEAD_BEEF, 1'b1, '0, bdq_pkg::ST_BADPOS, 15);
    plan_row(bdq_pkg::FN_INSERT, 4'd14, 32'h8000_0000, 1'b0, '0, bdq_pkg::ST_OK, 0);
    plan_row(bdq_pkg::FN_POP_BACK, 4'd0, '0, 1'b0, '0, bdq_pkg::ST_OK, 0);
    // longest shift: insert just behind the head
    plan_row(bdq_pkg::FN_INSERT, 4'd1, 32'h7FFF_FFFF, 1'b0, '0, bdq_pkg::ST_OK, 0);
    plan_row(FN_SPARE_HI, 4'd3, 32'h5555_AAAA, 1'b1, '0, bdq_pkg::ST_OK, 16);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[j]) begin
      send_item(plan[j].rq, plan[j].typed, plan[j].want);
    end

    filling = 1'b0;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      if (k >= RANDOM_ITEMS - QUIET_TAIL) begin
        gaps_on = 1'b0;
      end
      if (dq_count == bdq_pkg::CAPACITY) begin
        filling = 1'b0;
      end else if (dq_count == 0) begin
        filling = 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        filling = ~filling;
      end
      send_item(random_request(filling), 1'b0, '0);
    end
    req_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);  // catch stray results
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: compare accepted results, then pick next cycle's stall.
  // ---------------------------------------------------------------------------
  int rsp_hold = 0;

  always @(posedge clk) begin : result_check
    bdq_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: value %0d status %0d count %0d",
                 $time, rsp.popped_value, rsp.status, rsp.count);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (rsp.popped_value !== want.popped_value) begin
          $display("%0t: popped_value expected %0d got %0d",
                   $time, want.popped_value, rsp.popped_value);
          mismatches++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
          mismatches++;
        end
        if (rsp.count !== want.count) begin
          $display("%0t: count expected %0d got %0d", $time, want.count, rsp.count);
          mismatches++;
        end
      end
    end
    // stall bursts of random length, none in the quiet tail
    if (gaps_on && rsp_hold > 0) begin
      rsp_stall <= 1'b1;
      rsp_hold  = rsp_hold - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      rsp_stall <= 1'b1;
      rsp_hold  = $urandom_range(0, 5);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Watchdog, roughly ten times the slowest legal run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
